@@ rtl/core/hpw_pkg.sv @@
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared constants, types and helpers for the hierarchical page walker.
// ----------------------------------------------------------------------------
package hpw_pkg;

  localparam int OFFSET_BITS     = 3;
  localparam int PHYS_ADDR_WIDTH = 7;
  localparam int VIRT_ADDR_WIDTH = 12;
  localparam int TABLE_LEVELS    = 3;
  localparam int WORD_WIDTH      = 32;
  localparam int VA_IN_WIDTH     = 16;

  localparam int FRAME_BITS  = PHYS_ADDR_WIDTH - OFFSET_BITS;
  localparam int PAGE_BITS   = VIRT_ADDR_WIDTH - OFFSET_BITS;
  localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
  localparam int FRAME_COUNT = 1 << FRAME_BITS;
  localparam int PAGE_COUNT  = 1 << PAGE_BITS;
  localparam int PHYS_WORDS  = 1 << PHYS_ADDR_WIDTH;
  localparam int VIRT_WORDS  = 1 << VIRT_ADDR_WIDTH;
  localparam int LVL_BITS    = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;

  typedef logic [FRAME_BITS-1:0]      frame_t;
  typedef logic [PAGE_BITS-1:0]       page_t;
  typedef logic [OFFSET_BITS-1:0]     idx_t;
  typedef logic [PHYS_ADDR_WIDTH-1:0] paddr_t;
  typedef logic [VIRT_ADDR_WIDTH-1:0] vaddr_t;
  typedef logic [WORD_WIDTH-1:0]      word_t;
  typedef logic [LVL_BITS-1:0]        lvl_t;
  typedef logic [PAGE_BITS:0]         dist_t;

  // Outcome of a tree search
  typedef struct packed {
    frame_t empty_frame;
    frame_t max_frame;
    frame_t ev_frame;
    page_t  ev_page;
    paddr_t parent;
  } pick_t;

  // Search launch from the walker
  typedef struct packed {
    logic   start;
    frame_t base;
    page_t  target;
  } srch_req_t;

  // Memory write/read commands
  typedef struct packed {
    logic   we;
    paddr_t addr;
    word_t  wdata;
  } pm_cmd_t;

  typedef struct packed {
    logic   we;
    vaddr_t addr;
    word_t  wdata;
  } bs_cmd_t;

  // Cyclic distance between two page numbers
  function automatic dist_t cyc_dist(page_t a, page_t b);
    page_t d;
    dist_t w;
    d = (a > b) ? page_t'(a - b) : page_t'(b - a);
    w = dist_t'(PAGE_COUNT) - {1'b0, d};
    return (w < {1'b0, d}) ? w : {1'b0, d};
  endfunction

  // Table index of a page number at a given walk level
  function automatic idx_t level_index(page_t page, lvl_t lvl);
    page_t sh;
    sh = page >> (OFFSET_BITS * (TABLE_LEVELS - 1 - int'(lvl)));
    return sh[OFFSET_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/hpw_ram.sv @@
// ----------------------------------------------------------------------------
// hpw_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module hpw_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ rtl/core/hpw_search.sv @@
// ----------------------------------------------------------------------------
// hpw_search
// Depth-first search of the table tree: finds an empty table, the highest
// frame in use and the mapped page farthest from the target page.
// ----------------------------------------------------------------------------
module hpw_search import hpw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srch_req_t req_i,
  input  word_t     rdata_i,
  output paddr_t    rd_addr_o,
  output logic      busy_o,
  output logic      done_o,
  output pick_t     pick_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  typedef struct packed {
    frame_t best_frame;
    page_t  best_page;
    paddr_t best_parent;
    frame_t top;
  } acc_t;

  logic [2:0] state_q, state_d;
  lvl_t       dp_q, dp_d;
  frame_t     base_q, base_d;
  page_t      target_q, target_d;
  pick_t      pick_q, pick_d;

  // search stack, one row per tree level
  frame_t root_q [TABLE_LEVELS];
  frame_t root_d [TABLE_LEVELS];
  idx_t   idx_q  [TABLE_LEVELS];
  idx_t   idx_d  [TABLE_LEVELS];
  logic   empty_q [TABLE_LEVELS];
  logic   empty_d [TABLE_LEVELS];
  acc_t   acc_q  [TABLE_LEVELS];
  acc_t   acc_d  [TABLE_LEVELS];
  paddr_t par_q  [TABLE_LEVELS];
  paddr_t par_d  [TABLE_LEVELS];
  page_t  vpg_q  [TABLE_LEVELS];
  page_t  vpg_d  [TABLE_LEVELS];

  lvl_t   up_lvl, dn_lvl;
  paddr_t slot;
  page_t  cvpage;
  frame_t child;
  pick_t  leaf, fin;

  // fold one child's outcome into a level's running best
  function automatic acc_t merge(acc_t a, pick_t c, frame_t ch, page_t tgt);
    acc_t r;
    r = a;
    if (c.ev_frame != '0 &&
        (a.best_frame == '0 || cyc_dist(tgt, a.best_page) < cyc_dist(tgt, c.ev_page))) begin
      r.best_frame  = c.ev_frame;
      r.best_page   = c.ev_page;
      r.best_parent = c.parent;
    end
    if (c.max_frame > r.top) begin
      r.top = c.max_frame;
    end
    if (ch > r.top) begin
      r.top = ch;
    end
    return r;
  endfunction

  assign up_lvl    = dp_q - 1'b1;
  assign dn_lvl    = dp_q + 1'b1;
  assign slot      = {root_q[dp_q], idx_q[dp_q]};
  assign cvpage    = page_t'({vpg_q[dp_q], idx_q[dp_q]});
  assign child     = rdata_i[FRAME_BITS-1:0];
  assign rd_addr_o = slot;
  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = (state_q == S_DONE);
  assign pick_o    = pick_q;

  // leaf outcome and finished-level outcome
  always_comb begin
    leaf             = '0;
    leaf.ev_frame    = child;
    leaf.ev_page     = cvpage;
    leaf.parent      = slot;
    fin              = '0;
    if (empty_q[dp_q] && root_q[dp_q] != base_q) begin
      fin.empty_frame = root_q[dp_q];
      fin.parent      = par_q[dp_q];
    end else begin
      fin.max_frame = acc_q[dp_q].top;
      fin.ev_frame  = acc_q[dp_q].best_frame;
      fin.ev_page   = acc_q[dp_q].best_page;
      fin.parent    = acc_q[dp_q].best_parent;
    end
  end

  // traversal control
  always_comb begin
    state_d  = state_q;
    dp_d     = dp_q;
    base_d   = base_q;
    target_d = target_q;
    pick_d   = pick_q;
    root_d   = root_q;
    idx_d    = idx_q;
    empty_d  = empty_q;
    acc_d    = acc_q;
    par_d    = par_q;
    vpg_d    = vpg_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          base_d     = req_i.base;
          target_d   = req_i.target;
          dp_d       = '0;
          root_d[0]  = '0;
          idx_d[0]   = '0;
          empty_d[0] = 1'b1;
          acc_d[0]   = '0;
          par_d[0]   = '0;
          vpg_d[0]   = '0;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (rdata_i != '0 && dp_q != lvl_t'(TABLE_LEVELS - 1)) begin
          // descend into the child table
          empty_d[dp_q]         = 1'b0;
          dp_d                  = dn_lvl;
          root_d[dn_lvl]        = child;
          idx_d[dn_lvl]         = '0;
          empty_d[dn_lvl]       = 1'b1;
          acc_d[dn_lvl]         = '0;
          acc_d[dn_lvl].best_parent = slot;
          par_d[dn_lvl]         = slot;
          vpg_d[dn_lvl]         = cvpage;
          state_d               = S_READ;
        end else begin
          if (rdata_i != '0) begin
            empty_d[dp_q] = 1'b0;
            acc_d[dp_q]   = merge(acc_q[dp_q], leaf, child, target_q);
          end
          if (idx_q[dp_q] == '1) begin
            state_d = S_FIN;
          end else begin
            idx_d[dp_q] = idx_q[dp_q] + 1'b1;
            state_d     = S_READ;
          end
        end
      end
      S_FIN: begin
        if (dp_q == '0 || fin.empty_frame != '0) begin
          pick_d  = fin;
          state_d = S_DONE;
        end else begin
          acc_d[up_lvl] = merge(acc_q[up_lvl], fin, root_q[dp_q], target_q);
          dp_d          = up_lvl;
          if (idx_q[up_lvl] == '1) begin
            state_d = S_FIN;
          end else begin
            idx_d[up_lvl] = idx_q[up_lvl] + 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q     <= dp_d;
    base_q   <= base_d;
    target_q <= target_d;
    pick_q   <= pick_d;
    root_q   <= root_d;
    idx_q    <= idx_d;
    empty_q  <= empty_d;
    acc_q    <= acc_d;
    par_q    <= par_d;
    vpg_q    <= vpg_d;
  end

endmodule

@@ rtl/core/hpw_walker.sv @@
// ----------------------------------------------------------------------------
// hpw_walker
// Request sequencer: memory clear, table walk, fault service (unlink, page
// write-back, link, table clear or page load) and the final word access.
// ----------------------------------------------------------------------------
module hpw_walker import hpw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [VA_IN_WIDTH-1:0] virtual_address_i,
  input  word_t              write_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output word_t              read_data_o,
  input  word_t              pm_rdata_i,
  input  word_t              bs_rdata_i,
  output pm_cmd_t            pm_cmd_o,
  output bs_cmd_t            bs_cmd_o,
  output srch_req_t          srch_req_o,
  input  logic               srch_done_i,
  input  pick_t              srch_pick_i
);

  localparam logic [3:0] W_CLR   = 4'd0;
  localparam logic [3:0] W_IDLE  = 4'd1;
  localparam logic [3:0] W_WREAD = 4'd2;
  localparam logic [3:0] W_WCHK  = 4'd3;
  localparam logic [3:0] W_SRCH  = 4'd4;
  localparam logic [3:0] W_UNLNK = 4'd5;
  localparam logic [3:0] W_CPRD  = 4'd6;
  localparam logic [3:0] W_CPWR  = 4'd7;
  localparam logic [3:0] W_LINK  = 4'd8;
  localparam logic [3:0] W_ZERO  = 4'd9;
  localparam logic [3:0] W_FLRD  = 4'd10;
  localparam logic [3:0] W_FLWR  = 4'd11;
  localparam logic [3:0] W_AREQ  = 4'd12;
  localparam logic [3:0] W_ADAT  = 4'd13;
  localparam logic [3:0] W_DONE  = 4'd14;

  logic [3:0] state_q, state_d;
  vaddr_t     clr_q, clr_d;
  logic       mode_q, mode_d;
  vaddr_t     va_q, va_d;
  word_t      wdata_q, wdata_d;
  lvl_t       lvl_q, lvl_d;
  frame_t     cur_q, cur_d;
  paddr_t     slot_q, slot_d;
  frame_t     f_q, f_d;
  logic       evict_q, evict_d;
  idx_t       j_q, j_d;
  pick_t      pick_q, pick_d;
  logic       res_status_q, res_status_d;
  word_t      res_data_q, res_data_d;
  logic       out_valid_q, out_valid_d;
  logic       out_status_q, out_status_d;
  word_t      out_data_q, out_data_d;

  page_t page;
  logic  last_lvl;

  assign page        = va_q[VIRT_ADDR_WIDTH-1:OFFSET_BITS];
  assign last_lvl    = (lvl_q == lvl_t'(TABLE_LEVELS - 1));
  assign in_ready_o  = (state_q == W_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_data_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    mode_d       = mode_q;
    va_d         = va_q;
    wdata_d      = wdata_q;
    lvl_d        = lvl_q;
    cur_d        = cur_q;
    slot_d       = slot_q;
    f_d          = f_q;
    evict_d      = evict_q;
    j_d          = j_q;
    pick_d       = pick_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    pm_cmd_o     = '0;
    bs_cmd_o     = '0;
    srch_req_o        = '0;
    srch_req_o.base   = cur_q;
    srch_req_o.target = page;

    // output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      W_CLR: begin
        // zero the backing store and frame memory after reset
        pm_cmd_o.we   = 1'b1;
        pm_cmd_o.addr = clr_q[PHYS_ADDR_WIDTH-1:0];
        bs_cmd_o.we   = 1'b1;
        bs_cmd_o.addr = clr_q;
        if (clr_q == '1) begin
          state_d = W_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      W_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          va_d    = virtual_address_i[VIRT_ADDR_WIDTH-1:0];
          wdata_d = write_data_i;
          lvl_d   = '0;
          cur_d   = '0;
          if (|virtual_address_i[VA_IN_WIDTH-1:VIRT_ADDR_WIDTH]) begin
            res_status_d = 1'b1;
            res_data_d   = '0;
            state_d      = W_DONE;
          end else begin
            res_status_d = 1'b0;
            state_d      = W_WREAD;
          end
        end
      end
      W_WREAD: begin
        pm_cmd_o.addr = {cur_q, level_index(page, lvl_q)};
        slot_d        = {cur_q, level_index(page, lvl_q)};
        state_d       = W_WCHK;
      end
      W_WCHK: begin
        if (pm_rdata_i != '0) begin
          cur_d = pm_rdata_i[FRAME_BITS-1:0];
          if (last_lvl) begin
            state_d = W_AREQ;
          end else begin
            lvl_d   = lvl_q + 1'b1;
            state_d = W_WREAD;
          end
        end else begin
          srch_req_o.start = 1'b1;
          state_d          = W_SRCH;
        end
      end
      W_SRCH: begin
        if (srch_done_i) begin
          pick_d = srch_pick_i;
          j_d    = '0;
          if (srch_pick_i.empty_frame != '0) begin
            f_d     = srch_pick_i.empty_frame;
            evict_d = 1'b0;
            state_d = W_UNLNK;
          end else if (srch_pick_i.max_frame != frame_t'(FRAME_COUNT - 1)) begin
            f_d     = srch_pick_i.max_frame + 1'b1;
            state_d = W_LINK;
          end else begin
            f_d     = srch_pick_i.ev_frame;
            evict_d = 1'b1;
            state_d = W_UNLNK;
          end
        end
      end
      W_UNLNK: begin
        pm_cmd_o.we   = 1'b1;
        pm_cmd_o.addr = pick_q.parent;
        state_d       = evict_q ? W_CPRD : W_LINK;
      end
      // write the victim page back to the store
      W_CPRD: begin
        pm_cmd_o.addr = {f_q, j_q};
        state_d       = W_CPWR;
      end
      W_CPWR: begin
        bs_cmd_o.we    = 1'b1;
        bs_cmd_o.addr  = {pick_q.ev_page, j_q};
        bs_cmd_o.wdata = pm_rdata_i;
        if (j_q == '1) begin
          j_d     = '0;
          state_d = W_LINK;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = W_CPRD;
        end
      end
      W_LINK: begin
        pm_cmd_o.we    = 1'b1;
        pm_cmd_o.addr  = slot_q;
        pm_cmd_o.wdata = word_t'(f_q);
        j_d            = '0;
        state_d        = last_lvl ? W_FLRD : W_ZERO;
      end
      // clear a new table frame
      W_ZERO: begin
        pm_cmd_o.we   = 1'b1;
        pm_cmd_o.addr = {f_q, j_q};
        if (j_q == '1) begin
          cur_d   = f_q;
          lvl_d   = lvl_q + 1'b1;
          state_d = W_WREAD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      // load a new data frame from the store
      W_FLRD: begin
        bs_cmd_o.addr = {page, j_q};
        state_d       = W_FLWR;
      end
      W_FLWR: begin
        pm_cmd_o.we    = 1'b1;
        pm_cmd_o.addr  = {f_q, j_q};
        pm_cmd_o.wdata = bs_rdata_i;
        if (j_q == '1) begin
          cur_d   = f_q;
          state_d = W_AREQ;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = W_FLRD;
        end
      end
      W_AREQ: begin
        pm_cmd_o.addr = {cur_q, va_q[OFFSET_BITS-1:0]};
        if (mode_q) begin
          pm_cmd_o.we    = 1'b1;
          pm_cmd_o.wdata = wdata_q;
          res_data_d     = '0;
          state_d        = W_DONE;
        end else begin
          state_d = W_ADAT;
        end
      end
      W_ADAT: begin
        res_data_d = pm_rdata_i;
        state_d    = W_DONE;
      end
      W_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          state_d      = W_IDLE;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    va_q         <= va_d;
    wdata_q      <= wdata_d;
    lvl_q        <= lvl_d;
    cur_q        <= cur_d;
    slot_q       <= slot_d;
    f_q          <= f_d;
    evict_q      <= evict_d;
    j_q          <= j_d;
    pick_q       <= pick_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

endmodule

@@ rtl/core/hierarchical_page_walk_with_eviction.sv @@
// ----------------------------------------------------------------------------
// hierarchical_page_walk_with_eviction
// Word read/write through a three-level page table with demand paging.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one request: mode_i
//    (0 read, 1 write), a word virtual address and write data.
//  - Output channel (out_valid_o/out_ready_i) returns status_o (1 when the
//    address is out of range) and read_data_o (zero on writes and failures).
//  - A hit reads one table entry per table level, then does the word
//    access. A fault adds a depth-first scan of the table tree, then a
//    page write-back on eviction, and then a clear of a new table or a
//    load of a new data frame. All of it runs over the single port of
//    the frame memory.
//  - One request is in flight at a time; the next one is taken once the
//    current result sits in the output register.
//  - After reset the block clears the backing store and frame memory, one
//    word a cycle, with in_ready_o low.
//  - When the receiver stalls, the result waits in the output register and
//    a following request is held at its last step until the register frees.
// ----------------------------------------------------------------------------
module hierarchical_page_walk_with_eviction import hpw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [VA_IN_WIDTH-1:0]  virtual_address_i,
  input  logic signed [31:0]      write_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic signed [31:0]      read_data_o
);

  pm_cmd_t   pm_cmd;
  bs_cmd_t   bs_cmd;
  srch_req_t srch_req;
  pick_t     srch_pick;
  word_t     pm_rdata, bs_rdata, rdata;
  paddr_t    srch_addr, pm_addr;
  logic      srch_busy, srch_done;

  // search owns the frame memory port while it runs
  assign pm_addr     = srch_busy ? srch_addr : pm_cmd.addr;
  assign read_data_o = rdata;

  hpw_ram #(
    .Width (WORD_WIDTH),
    .Depth (PHYS_WORDS)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (pm_cmd.we),
    .addr_i  (pm_addr),
    .wdata_i (pm_cmd.wdata),
    .rdata_o (pm_rdata)
  );

  hpw_ram #(
    .Width (WORD_WIDTH),
    .Depth (VIRT_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (bs_cmd.we),
    .addr_i  (bs_cmd.addr),
    .wdata_i (bs_cmd.wdata),
    .rdata_o (bs_rdata)
  );

  hpw_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (srch_req),
    .rdata_i   (pm_rdata),
    .rd_addr_o (srch_addr),
    .busy_o    (srch_busy),
    .done_o    (srch_done),
    .pick_o    (srch_pick)
  );

  hpw_walker u_walker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .virtual_address_i (virtual_address_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .read_data_o       (rdata),
    .pm_rdata_i        (pm_rdata),
    .bs_rdata_i        (bs_rdata),
    .pm_cmd_o          (pm_cmd),
    .bs_cmd_o          (bs_cmd),
    .srch_req_o        (srch_req),
    .srch_done_i       (srch_done),
    .srch_pick_i       (srch_pick)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the hierarchical page walker. A behavioral copy of the page
// table, the frame memory and the backing store predicts each response. Named
// test tasks send directed and random requests with random gaps on both
// channels. A monitor checks every response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import hpw_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 600;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_RANGE   = 1'b1;

  typedef struct {
    logic       status;
    logic [31:0] data;
  } resp_t;

  typedef struct {
    int empty_frame;
    int max_frame;
    int ev_frame;
    int ev_page;
    int parent;
  } victim_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   mode_i;
  logic [VA_IN_WIDTH-1:0] virtual_address_i;
  logic signed [31:0]     write_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   status_o;
  logic signed [31:0]     read_data_o;

  hierarchical_page_walk_with_eviction dut (.*);

  // Shadow memories of the block
  word_t frame_mem [PHYS_WORDS];
  word_t swap_mem  [VIRT_WORDS];

  resp_t pending_resp [$];
  int    error_count;
  int    gap_next;
  bit    hold_request;
  bit    long_hold_done;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int page_dist(int a, int b);
    int d;
    int w;
    d = (a > b) ? a - b : b - a;
    w = PAGE_COUNT - d;
    return (w < d) ? w : d;
  endfunction

  function automatic int frame_base(int f);
    return (f & (FRAME_COUNT - 1)) << OFFSET_BITS;
  endfunction

  // Depth-first scan of the table tree for a frame to hand out
  function automatic victim_t tree_scan(int base, int target, int root, int depth,
                                        int parent, int vpage);
    victim_t r;
    victim_t c;
    int best_f;
    int best_p;
    int top;
    int best_par;
    bit empty;
    int slot;
    int child;
    r = '{0, 0, 0, 0, 0};
    best_f = 0;
    best_p = 0;
    top = 0;
    best_par = parent;
    empty = 1'b1;
    if (depth >= TABLE_LEVELS) begin
      r.ev_frame = root;
      r.ev_page = vpage;
      r.parent = parent;
      return r;
    end
    for (int i = 0; i < PAGE_WORDS; i++) begin
      slot = frame_base(root) + i;
      if (frame_mem[slot] != '0) begin
        child = frame_mem[slot] & (FRAME_COUNT - 1);
        empty = 1'b0;
        c = tree_scan(base, target, child, depth + 1, slot, vpage * PAGE_WORDS + i);
        if (c.empty_frame != 0) return c;
        if (c.ev_frame != 0 &&
            (best_f == 0 || page_dist(target, best_p) < page_dist(target, c.ev_page))) begin
          best_f = c.ev_frame;
          best_p = c.ev_page;
          best_par = c.parent;
        end
        if (c.max_frame > top) top = c.max_frame;
        if (child > top) top = child;
      end
    end
    if (empty && root != base) begin
      r.empty_frame = root;
      r.parent = parent;
      return r;
    end
    r.max_frame = top;
    r.ev_frame = best_f;
    r.ev_page = best_p;
    r.parent = best_par;
    return r;
  endfunction

  // Translate a page, faulting in tables and data frames as needed
  function automatic int translate_page(int page);
    int cur;
    int nxt;
    int idx;
    int slot;
    int f;
    victim_t v;
    cur = 0;
    nxt = 0;
    for (int lvl = 0; lvl < TABLE_LEVELS; lvl++) begin
      idx = (page >> (OFFSET_BITS * (TABLE_LEVELS - 1 - lvl))) & (PAGE_WORDS - 1);
      slot = frame_base(cur) + idx;
      nxt = frame_mem[slot] & (FRAME_COUNT - 1);
      if (frame_mem[slot] == '0) begin
        v = tree_scan(cur, page, 0, 0, 0, 0);
        if (v.empty_frame != 0) begin
          f = v.empty_frame;
          frame_mem[v.parent & (PHYS_WORDS - 1)] = '0;
        end else if (v.max_frame != FRAME_COUNT - 1) begin
          f = v.max_frame + 1;
        end else begin
          f = v.ev_frame;
          frame_mem[v.parent & (PHYS_WORDS - 1)] = '0;
          for (int j = 0; j < PAGE_WORDS; j++)
            swap_mem[((v.ev_page & (PAGE_COUNT - 1)) * PAGE_WORDS + j) & (VIRT_WORDS - 1)] =
              frame_mem[frame_base(f) + j];
        end
        f = f & (FRAME_COUNT - 1);
        frame_mem[slot] = word_t'(f);
        for (int j = 0; j < PAGE_WORDS; j++)
          frame_mem[frame_base(f) + j] = (lvl + 1 >= TABLE_LEVELS) ?
            swap_mem[((page & (PAGE_COUNT - 1)) * PAGE_WORDS + j) & (VIRT_WORDS - 1)] : '0;
        nxt = f;
      end
      cur = nxt;
    end
    return nxt;
  endfunction

  // Response that an accepted request produces
  function automatic resp_t access_result(logic mode, logic [15:0] va, logic [31:0] wd);
    resp_t r;
    int addr;
    r.status = ST_OK;
    r.data = '0;
    if (va >= VIRT_WORDS) begin
      r.status = ST_RANGE;
      return r;
    end
    addr = frame_base(translate_page(va >> OFFSET_BITS)) + (va & (PAGE_WORDS - 1));
    if (mode == MODE_WRITE) frame_mem[addr] = wd;
    else r.data = frame_mem[addr];
    return r;
  endfunction

  // Send one request and record its prediction on acceptance
  task automatic send_request(logic mode, logic [15:0] va, logic [31:0] wd);
    repeat (gap_next) @(posedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    virtual_address_i <= va;
    write_data_i <= wd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_resp.push_back(access_result(mode, va, wd));
    gap_next = pick_gap();
    if (gap_next > 0) in_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
        out_ready_i <= 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected response status=%0b data=%h", $time, status_o, read_data_o);
        error_count++;
      end else begin
        e = pending_resp.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0b actual %0b", $time, e.status, status_o);
          error_count++;
        end
        if (read_data_o !== e.data) begin
          $display("%0t: read_data expected %h actual %h", $time, e.data, read_data_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int idle;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic test_basic_access();
    send_request(MODE_READ, 16'd0, 32'd0);
    send_request(MODE_WRITE, 16'd0, 32'h7fff_ffff);
    send_request(MODE_READ, 16'd0, 32'hffff_ffff);
    send_request(MODE_WRITE, 16'd7, 32'h8000_0000);
    send_request(MODE_READ, 16'd7, 32'd0);
    send_request(MODE_WRITE, 16'd1, 32'hffff_ffff);
    send_request(MODE_READ, 16'd1, 32'd0);
  endtask

  task automatic test_range_limits();
    send_request(MODE_WRITE, 16'(VIRT_WORDS - 1), 32'h5a5a_a5a5);
    send_request(MODE_READ, 16'(VIRT_WORDS - 1), 32'd0);
    send_request(MODE_READ, 16'(VIRT_WORDS), 32'd0);
    send_request(MODE_WRITE, 16'(VIRT_WORDS), 32'h1234_5678);
    send_request(MODE_READ, 16'hffff, 32'hffff_ffff);
    send_request(MODE_WRITE, 16'hffff, 32'hffff_ffff);
  endtask

  // Touch many scattered pages so that frames run out and pages swap
  task automatic test_eviction();
    for (int i = 0; i < 8; i++)
      send_request(MODE_WRITE, 16'(i * 517 % VIRT_WORDS), $urandom());
    for (int i = 0; i < 4; i++)
      send_request(MODE_READ, 16'(i * 517 % VIRT_WORDS), 32'd0);
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request(logic'($urandom_range(0, 1)), 16'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic test_random(int count);
    int sel;
    logic [15:0] va;
    logic [15:0] work_set [8];
    foreach (work_set[i]) work_set[i] = 16'($urandom_range(0, VIRT_WORDS - 1));
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) va = work_set[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 7));
      else if (sel < 90) va = 16'($urandom_range(0, VIRT_WORDS - 1));
      else va = 16'($urandom());
      if ($urandom_range(0, 15) == 0)
        work_set[$urandom_range(0, 7)] = 16'($urandom_range(0, VIRT_WORDS - 1));
      send_request(logic'($urandom_range(0, 1)), va, $urandom());
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    mode_i = MODE_READ;
    virtual_address_i = '0;
    write_data_i = '0;
    error_count = 0;
    gap_next = 0;
    hold_request = 1'b0;
    long_hold_done = 1'b0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (swap_mem[i]) swap_mem[i] = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_access();
    test_range_limits();
    test_eviction();
    test_backpressure();
    test_random(660);

    if (gap_next > 0) @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hpw_pkg.sv
rtl/core/hpw_ram.sv
rtl/core/hpw_search.sv
rtl/core/hpw_walker.sv
rtl/core/hierarchical_page_walk_with_eviction.sv
bench/tb_top.sv
